// ===== rtl/core/compacting_key_value_table_core_defines.svh =====
// Assertion macros for the compacting key/value table core
`ifndef COMPACTING_KEY_VALUE_TABLE_CORE_DEFINES_SVH
`define COMPACTING_KEY_VALUE_TABLE_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// property checked on every rising clock edge out of reset
`define CKVT_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// condition that must never hold out of reset
`define CKVT_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define CKVT_ASSERT(lbl, clk, rstn, prop, msg)
`define CKVT_NEVER(lbl, clk, rstn, cond, msg)
`endif

`endif

// ===== rtl/core/ckvt_pkg.sv =====
// Shared types and constants for the compacting key/value table core
`timescale 1ns / 1ps
package ckvt_pkg;

    localparam int CAPACITY_DEF   = 16;
    localparam int KEY_BITS_DEF   = 16;
    localparam int VALUE_BITS_DEF = 16;
    localparam int FUNC_W         = 2;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_DELETE = 2'd1,
        FUNC_LOOKUP = 2'd2,
        FUNC_SPARE  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_IDLE    = 2'd0,
        ST_COMPARE = 2'd1,
        ST_UPDATE  = 2'd2
    } state_t;

    typedef struct packed {
        logic cmp_en;
        logic shift_en;
        logic ins_en;
    } cell_ctrl_t;

endpackage

// ===== rtl/core/ckvt_cell.sv =====
// One table slot: key/value storage, key compare and shift-down from its neighbour
`timescale 1ns / 1ps
module ckvt_cell #(
    parameter int KEY_BITS   = 16,
    parameter int VALUE_BITS = 16,
    parameter int CNT_W      = 5,
    parameter int INDEX      = 0
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  ckvt_pkg::cell_ctrl_t   ctrl,
    input  logic [CNT_W-1:0]       count,
    input  logic [KEY_BITS-1:0]    req_key,
    input  logic [VALUE_BITS-1:0]  req_value,
    input  logic [KEY_BITS-1:0]    next_key,
    input  logic [VALUE_BITS-1:0]  next_value,
    input  logic                   shift_in,
    output logic                   shift_out,
    output logic                   match,
    output logic [KEY_BITS-1:0]    key,
    output logic [VALUE_BITS-1:0]  value
);
    import ckvt_pkg::*;

    localparam logic [CNT_W-1:0] SLOT = CNT_W'(INDEX);

    logic                  match_reg, match_next;
    logic [KEY_BITS-1:0]   key_reg, key_next;
    logic [VALUE_BITS-1:0] value_reg, value_next;
    logic                  occupied;

    assign occupied  = SLOT < count;
    assign shift_out = shift_in | match_reg;

    always_comb begin
        match_next = match_reg;
        key_next   = key_reg;
        value_next = value_reg;
        if (ctrl.cmp_en) begin
            match_next = occupied && (key_reg == req_key);
        end
        if (ctrl.ins_en && (count == SLOT)) begin
            key_next   = req_key;
            value_next = req_value;
        end else if (ctrl.shift_en && shift_out) begin
            key_next   = next_key;
            value_next = next_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            match_reg <= 1'b0;
        end else begin
            match_reg <= match_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg   <= key_next;
        value_reg <= value_next;
    end

    assign match = match_reg;
    assign key   = key_reg;
    assign value = value_reg;

endmodule

// ===== rtl/core/compacting_key_value_table_core.sv =====
// Top level of the compacting key/value table core
// Compacting key/value table: up to CAPACITY pairs held densely in insertion order.
// Input channel s_*: one request per item, tdata = {new_value, key, func} from bit 0
// (func 0 insert, 1 delete, 2 lookup, 3 acts as lookup).
// Result channel m_*: one item per request, tdata = {table_full, entry_count,
// refused, read_value, found} from bit 0.
// Each accepted request passes through a compare state in which every cell checks
// its key in parallel, then an update state in which the chain of cells appends,
// shifts down to close a gap, or holds. The result is registered at the end of the
// update state. A new request can be accepted in the update state once the result
// register is free, so a request overlaps with the update of the one before it.
// If the receiver stalls with a result still held, the block finishes the compare
// of the next request and then waits in the update state until the result is taken.
// Reset (aresetn low, synchronous) empties the table and drops any pending result;
// stored keys and values are not cleared, only the entry count.
`timescale 1ns / 1ps
`include "compacting_key_value_table_core_defines.svh"
module compacting_key_value_table_core #(
    parameter int CAPACITY   = ckvt_pkg::CAPACITY_DEF,
    parameter int KEY_BITS   = ckvt_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS = ckvt_pkg::VALUE_BITS_DEF,
    localparam int CNT_W     = $clog2(CAPACITY + 1),
    localparam int IN_W      = ckvt_pkg::FUNC_W + KEY_BITS + VALUE_BITS,
    localparam int S_W       = ((IN_W + 7) / 8) * 8,
    localparam int OUT_W     = 3 + VALUE_BITS + CNT_W,
    localparam int M_W       = ((OUT_W + 7) / 8) * 8
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [S_W-1:0] s_tdata,  // func, key, new_value
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [M_W-1:0] m_tdata   // found, read_value, refused, entry_count, table_full
);
    import ckvt_pkg::*;

    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    state_t                state_reg, state_next;
    func_t                 func_reg, func_next;
    logic [KEY_BITS-1:0]   key_reg, key_next;
    logic [VALUE_BITS-1:0] newval_reg, newval_next;
    logic [CNT_W-1:0]      count_reg, count_next;

    logic                  out_valid_reg, out_valid_next;
    logic                  found_reg, found_next;
    logic [VALUE_BITS-1:0] rv_reg, rv_next;
    logic                  refused_reg, refused_next;
    logic [CNT_W-1:0]      ocount_reg, ocount_next;
    logic                  full_reg, full_next;

    cell_ctrl_t            ctrl;
    logic                  accept, upd_go, hit, is_ins, is_del;
    logic [VALUE_BITS-1:0] hit_value;

    logic [KEY_BITS-1:0]   cell_key   [CAPACITY];
    logic [VALUE_BITS-1:0] cell_value [CAPACITY];
    logic [CAPACITY-1:0]   match_vec;
    logic [CAPACITY:0]     shift_chain;

    assign shift_chain[0] = 1'b0;

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [KEY_BITS-1:0]   nk;
        logic [VALUE_BITS-1:0] nv;
        if (i < CAPACITY - 1) begin : g_mid
            assign nk = cell_key[i+1];
            assign nv = cell_value[i+1];
        end else begin : g_end
            assign nk = cell_key[i];
            assign nv = cell_value[i];
        end
        ckvt_cell #(
            .KEY_BITS  (KEY_BITS),
            .VALUE_BITS(VALUE_BITS),
            .CNT_W     (CNT_W),
            .INDEX     (i)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (ctrl),
            .count     (count_reg),
            .req_key   (key_reg),
            .req_value (newval_reg),
            .next_key  (nk),
            .next_value(nv),
            .shift_in  (shift_chain[i]),
            .shift_out (shift_chain[i+1]),
            .match     (match_vec[i]),
            .key       (cell_key[i]),
            .value     (cell_value[i])
        );
    end

    // keys are unique, so at most one cell contributes
    always_comb begin
        hit_value = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            hit_value = hit_value | (cell_value[i] & {VALUE_BITS{match_vec[i]}});
        end
    end

    assign hit    = |match_vec;
    assign is_ins = (func_reg == FUNC_INSERT);
    assign is_del = (func_reg == FUNC_DELETE);
    assign upd_go = !out_valid_reg || m_tready;

    always_comb begin
        state_next     = state_reg;
        func_next      = func_reg;
        key_next       = key_reg;
        newval_next    = newval_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        found_next     = found_reg;
        rv_next        = rv_reg;
        refused_next   = refused_reg;
        ocount_next    = ocount_reg;
        full_next      = full_reg;
        ctrl           = '0;
        s_tready       = 1'b0;

        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
            end
            ST_COMPARE: begin
                ctrl.cmp_en = 1'b1;
                state_next  = ST_UPDATE;
            end
            ST_UPDATE: begin
                if (upd_go) begin
                    s_tready       = 1'b1;
                    ctrl.ins_en    = is_ins && !hit && (count_reg != CAP_CNT);
                    ctrl.shift_en  = is_del && hit;
                    if (ctrl.ins_en) begin
                        count_next = count_reg + 1'b1;
                    end else if (ctrl.shift_en) begin
                        count_next = count_reg - 1'b1;
                    end
                    out_valid_next = 1'b1;
                    found_next     = hit;
                    rv_next        = hit_value;
                    refused_next   = is_ins && !hit && (count_reg == CAP_CNT);
                    ocount_next    = count_next;
                    full_next      = (count_next == CAP_CNT);
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        accept = s_tvalid && s_tready;
        if (accept) begin
            func_next   = func_t'(s_tdata[FUNC_W-1:0]);
            key_next    = s_tdata[FUNC_W +: KEY_BITS];
            newval_next = s_tdata[FUNC_W + KEY_BITS +: VALUE_BITS];
            state_next  = ST_COMPARE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        func_reg    <= func_next;
        key_reg     <= key_next;
        newval_reg  <= newval_next;
        found_reg   <= found_next;
        rv_reg      <= rv_next;
        refused_reg <= refused_next;
        ocount_reg  <= ocount_next;
        full_reg    <= full_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_W'({full_reg, ocount_reg, refused_reg, rv_reg, found_reg});

    `CKVT_NEVER(a_count_bound, aclk, aresetn, count_reg > CAP_CNT, "entry count above capacity")
    `CKVT_ASSERT(a_unique_key, aclk, aresetn, $onehot0(match_vec), "key held in two cells")
    `CKVT_ASSERT(a_refuse_full, aclk, aresetn, (m_tvalid && refused_reg) |-> full_reg, "refused while not full")
    `CKVT_ASSERT(a_accept_cmp, aclk, aresetn, (s_tvalid && s_tready) |=> (state_reg == ST_COMPARE), "no compare after accept")

endmodule

// ===== tb/tb_compacting_key_value_table_core.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the compacting key/value table core: directed table, then random
module tb_compacting_key_value_table_core;
    import ckvt_pkg::*;

    localparam int CAP        = CAPACITY_DEF;
    localparam int KW         = KEY_BITS_DEF;
    localparam int VW         = VALUE_BITS_DEF;
    localparam int CNT_W      = $clog2(CAP + 1);
    localparam int IN_W       = FUNC_W + KW + VW;
    localparam int S_W        = ((IN_W + 7) / 8) * 8;
    localparam int OUT_W      = 3 + VW + CNT_W;
    localparam int M_W        = ((OUT_W + 7) / 8) * 8;
    localparam int N_RANDOM   = 925;
    localparam int POOL_SIZE  = 24;
    localparam int HOLD_LEN   = 200;
    localparam int IDLE_LIMIT = 3000;
    localparam int DRAIN_WAIT = 8;

    // bit 0 upwards: found, read_value, refused, entry_count, table_full
    typedef struct packed {
        logic             table_full;
        logic [CNT_W-1:0] entry_count;
        logic             refused;
        logic [VW-1:0]    read_value;
        logic             found;
    } kv_result_t;

    typedef struct {
        func_t         op;
        logic [KW-1:0] key;
        logic [VW-1:0] val;
        bit            typed;
        kv_result_t    want;
    } req_row_t;

    logic           aclk;
    logic           aresetn;
    logic           s_tvalid;
    logic           s_tready;
    logic [S_W-1:0] s_tdata;   // func, key, new_value
    logic           m_tvalid;
    logic           m_tready;
    logic [M_W-1:0] m_tdata;   // found, read_value, refused, entry_count, table_full

    logic [KW-1:0] model_keys [CAP];
    logic [VW-1:0] model_vals [CAP];
    int            model_count;

    kv_result_t    pending_results [$];
    req_row_t      directed_rows [$];
    logic [KW-1:0] key_pool [POOL_SIZE];
    int            bad_results;
    int            idle_cycles;
    bit            no_idle;
    bit            hold_req;

    compacting_key_value_table_core uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic kv_result_t mk_result(bit f, logic [VW-1:0] rv, bit rf, int cnt, bit full);
        kv_result_t r;
        r.found       = f;
        r.read_value  = rv;
        r.refused     = rf;
        r.entry_count = cnt[CNT_W-1:0];
        r.table_full  = full;
        return r;
    endfunction

    function automatic void add_row(func_t op, logic [KW-1:0] k, logic [VW-1:0] v,
                                    bit typed, kv_result_t want);
        req_row_t row;
        row.op    = op;
        row.key   = k;
        row.val   = v;
        row.typed = typed;
        row.want  = want;
        directed_rows.push_back(row);
    endfunction

    // updates the shadow table and returns the result of one request
    function automatic kv_result_t table_apply(func_t op, logic [KW-1:0] k, logic [VW-1:0] v);
        int idx;
        int i;
        bit hit;
        kv_result_t r;
        idx = model_count;
        for (i = 0; i < model_count; i++) begin
            if (model_keys[i] == k) begin
                idx = i;
                break;
            end
        end
        hit = idx < model_count;
        r = '0;
        r.found = hit;
        if (hit) r.read_value = model_vals[idx];
        case (op)
            FUNC_INSERT: begin
                if (!hit) begin
                    if (model_count >= CAP) begin
                        r.refused = 1'b1;
                    end else begin
                        model_keys[model_count] = k;
                        model_vals[model_count] = v;
                        model_count++;
                    end
                end
            end
            FUNC_DELETE: begin
                if (hit) begin
                    for (i = idx + 1; i < model_count; i++) begin
                        model_keys[i-1] = model_keys[i];
                        model_vals[i-1] = model_vals[i];
                    end
                    model_count--;
                end
            end
            default: ;
        endcase
        r.entry_count = model_count[CNT_W-1:0];
        r.table_full  = (model_count == CAP);
        return r;
    endfunction

    task automatic send_req(func_t op, logic [KW-1:0] k, logic [VW-1:0] v,
                            bit typed, kv_result_t want);
        int gap;
        kv_result_t predicted;
        gap = no_idle ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_W-IN_W){1'b0}}, v, k, op};
        do @(posedge aclk); while (!s_tready);
        predicted = table_apply(op, k, v);
        pending_results.push_back(typed ? want : predicted);
    endtask

    // result side
    initial begin
        int gap;
        kv_result_t got;
        kv_result_t want;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (hold_req) begin
                gap = HOLD_LEN;
                hold_req = 1'b0;
            end else if (no_idle) begin
                gap = 0;
            end else begin
                gap = $urandom_range(0, 15);
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            got = kv_result_t'(m_tdata[OUT_W-1:0]);
            if (pending_results.size() == 0) begin
                bad_results++;
                if (bad_results <= 10)
                    $display("%0t unexpected result item %h", $realtime, got);
            end else begin
                want = pending_results.pop_front();
                if (got.found !== want.found || got.read_value !== want.read_value ||
                    got.refused !== want.refused || got.entry_count !== want.entry_count ||
                    got.table_full !== want.table_full) begin
                    bad_results++;
                    if (bad_results <= 10) begin
                        $display("%0t mismatch: exp found=%0d value=%h refused=%0d count=%0d full=%0d",
                                 $realtime, want.found, want.read_value, want.refused,
                                 want.entry_count, want.table_full);
                        $display("    got found=%0d value=%h refused=%0d count=%0d full=%0d",
                                 got.found, got.read_value, got.refused, got.entry_count,
                                 got.table_full);
                    end
                end
            end
        end
    end

    // watchdog on handshake activity
    always @(posedge aclk) begin
        if (!aresetn) begin
            idle_cycles <= 0;
        end else begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
                if (idle_cycles + 1 >= IDLE_LIMIT) begin
                    $display("compacting_key_value_table_core test failed");
                    $finish;
                end
            end
        end
    end

    initial begin
        int i;
        int ins_pct;
        int r;
        func_t op;
        logic [KW-1:0] k;
        aresetn     <= 1'b0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        m_tready    <= 1'b0;
        bad_results = 0;
        model_count = 0;
        no_idle     = 1'b0;
        hold_req    = 1'b0;
        for (i = 0; i < CAP; i++) begin
            model_keys[i] = '0;
            model_vals[i] = '0;
        end
        for (i = 0; i < POOL_SIZE; i++) key_pool[i] = KW'($urandom);

        add_row(FUNC_LOOKUP, 16'h0000, 16'h0000, 1, mk_result(0, 16'h0000, 0, 0, 0));
        add_row(FUNC_DELETE, 16'hFFFF, 16'hFFFF, 1, mk_result(0, 16'h0000, 0, 0, 0));
        add_row(FUNC_INSERT, 16'h0000, 16'hFFFF, 1, mk_result(0, 16'h0000, 0, 1, 0));
        add_row(FUNC_INSERT, 16'hFFFF, 16'h0000, 1, mk_result(0, 16'h0000, 0, 2, 0));
        add_row(FUNC_LOOKUP, 16'hFFFF, 16'h1234, 1, mk_result(1, 16'h0000, 0, 2, 0));
        // present key: stored value kept
        add_row(FUNC_INSERT, 16'h0000, 16'h1234, 1, mk_result(1, 16'hFFFF, 0, 2, 0));
        add_row(FUNC_SPARE,  16'h0000, 16'h0000, 1, mk_result(1, 16'hFFFF, 0, 2, 0));
        for (i = 0; i < CAP - 2; i++)
            add_row(FUNC_INSERT, KW'(16'h0100 + i), VW'($urandom), 0, '0);
        // full table refuses a new key
        add_row(FUNC_INSERT, 16'hABCD, 16'h5555, 1, mk_result(0, 16'h0000, 1, CAP, 1));
        add_row(FUNC_DELETE, 16'h0000, 16'h0000, 0, '0);
        add_row(FUNC_DELETE, KW'(16'h0100 + CAP - 3), 16'h0000, 0, '0);
        add_row(FUNC_LOOKUP, 16'hFFFF, 16'h0000, 0, '0);

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[n])
            send_req(directed_rows[n].op, directed_rows[n].key, directed_rows[n].val,
                     directed_rows[n].typed, directed_rows[n].want);

        ins_pct = 50;
        for (i = 0; i < N_RANDOM; i++) begin
            if (i % 50 == 0) begin
                case ($urandom_range(0, 2))
                    0: ins_pct = 80;
                    1: ins_pct = 50;
                    default: ins_pct = 20;
                endcase
            end
            if (i == 200) hold_req = 1'b1;
            if (i == 500) begin
                s_tvalid <= 1'b0;
                do @(posedge aclk); while (pending_results.size() != 0);
            end
            no_idle = (i >= 650 && i < 720);
            r = $urandom_range(0, 99);
            if (r < ins_pct) begin
                op = FUNC_INSERT;
            end else begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: op = FUNC_DELETE;
                    6, 7, 8:          op = FUNC_LOOKUP;
                    default:          op = FUNC_SPARE;
                endcase
            end
            k = ($urandom_range(0, 9) == 0) ? KW'($urandom)
                                            : key_pool[$urandom_range(0, POOL_SIZE-1)];
            send_req(op, k, VW'($urandom), 0, '0);
        end
        no_idle = 1'b0;

        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (bad_results == 0 && pending_results.size() == 0) begin
            $display("compacting_key_value_table_core test passed");
        end else begin
            $display("compacting_key_value_table_core test failed");
        end
        $finish;
    end
endmodule
